>>> rtl/matrix4_inverse_cofactor_unit_defines.svh
// Assertion macros for the 4x4 matrix inverse unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MATRIX4_INVERSE_COFACTOR_UNIT_DEFINES_SVH
`define MATRIX4_INVERSE_COFACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mic_pkg.sv
// Package for the 4x4 matrix inverse unit: widths, operand tables, types.
// No dependencies.
package mic_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 4;
    localparam int THR_W      = 31;
    localparam int SUB_W      = 64 - FRAC_BITS;
    localparam int HALF_W     = (SUB_W + 1) / 2;
    localparam int ACC_W      = 2 * SUB_W + 4;
    localparam int DEN_W      = ACC_W + 1;
    localparam int NUM_W      = ACC_W + FRAC_BITS + 2;
    localparam int QUO_W      = 34;
    localparam int DIV_W      = ACC_W + QUO_W + 2;
    localparam int DCNT_W     = $clog2(QUO_W);
    localparam int SUB_N      = 12;
    localparam int ELEM_N     = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(6);
    localparam logic             REG_THR   = 1'b0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 4'd15;
    localparam logic [IDX_W-1:0] K_LAST_SUB = 4'd11;
    localparam logic [2:0]       T_LAST_SUB = 3'd1;
    localparam logic [2:0]       T_LAST_DET = 3'd5;
    localparam logic [2:0]       T_LAST_ADJ = 3'd2;
    localparam logic [2:0]       MAC_LAST   = 3'd4;

    typedef enum logic [1:0] {PH_SUB, PH_DET, PH_ADJ} t_phase;

    typedef struct packed {
        logic             a_sub;
        logic [IDX_W-1:0] a_idx;
        logic             b_sub;
        logic [IDX_W-1:0] b_idx;
        logic             neg;
    } t_op;

    typedef struct packed {
        logic start;
        logic clr;
        logic neg;
    } t_mac_cmd;

    typedef struct packed {
        logic busy;
    } t_mac_st;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quo;
    } t_div_st;

    // sub-determinant k: e[a0]*e[b0] - e[a1]*e[b1], nibbles a0 b0 a1 b1
    localparam logic [15:0] SUB_ROW [SUB_N] = '{
        16'h0514, 16'h0624, 16'h0734, 16'h1625, 16'h1735, 16'h2736,
        16'h8D9C, 16'h8EAC, 16'h8FBC, 16'h9EAD, 16'h9FBD, 16'hAFBE
    };

    // adjugate entry: lead sign, three elements, three sub-determinants
    localparam logic [27:0] ADJ_ROW [ELEM_N] = '{
        28'h1567BA9, 28'h0123BA9, 28'h1DEF543, 28'h09AB543,
        28'h0467B87, 28'h1023B87, 28'h0CEF521, 28'h18AB521,
        28'h1457A86, 28'h0013A86, 28'h1CDF420, 28'h089B420,
        28'h0456976, 28'h1012976, 28'h0CDE310, 28'h189A310
    };

    function automatic t_op op_decode(t_phase ph, logic [IDX_W-1:0] k, logic [2:0] t);
        t_op         op;
        logic [15:0] srow;
        logic [27:0] arow;
        op   = '0;
        srow = SUB_ROW[k];
        arow = ADJ_ROW[k];
        case (ph)
            PH_SUB: begin
                if (!t[0]) begin
                    op.a_idx = srow[15:12];
                    op.b_idx = srow[11:8];
                end else begin
                    op.a_idx = srow[7:4];
                    op.b_idx = srow[3:0];
                    op.neg   = 1'b1;
                end
            end
            PH_DET: begin
                op.a_sub = 1'b1;
                op.b_sub = 1'b1;
                op.a_idx = IDX_W'(t);
                op.b_idx = K_LAST_SUB - IDX_W'(t);
                op.neg   = (t == 3'd1) || (t == 3'd4);
            end
            PH_ADJ: begin
                op.b_sub = 1'b1;
                op.neg   = !(arow[24] ^ t[0]);
                case (t)
                    3'd0: begin
                        op.a_idx = arow[23:20];
                        op.b_idx = arow[11:8];
                    end
                    3'd1: begin
                        op.a_idx = arow[19:16];
                        op.b_idx = arow[7:4];
                    end
                    default: begin
                        op.a_idx = arow[15:12];
                        op.b_idx = arow[3:0];
                    end
                endcase
            end
            default: op = '0;
        endcase
        return op;
    endfunction

endpackage

>>> rtl/mic_in_if.sv
// Element input channel: valid/ready with index and value.
// Depends on mic_pkg.
interface mic_in_if;
    import mic_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
    modport source (output valid, elem_index, elem_value, input ready);
    modport sink   (input valid, elem_index, elem_value, output ready);
endinterface

>>> rtl/mic_out_if.sv
// Result output channel: valid/ready with index, value and flags.
// Depends on mic_pkg.
interface mic_out_if;
    import mic_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_index;
    logic signed [ELEM_W-1:0] out_value;
    logic                     singular;
    logic                     last;
    modport source (output valid, out_index, out_value, singular, last, input ready);
    modport sink   (input valid, out_index, out_value, singular, last, output ready);
endinterface

>>> rtl/mic_mac.sv
// Shared signed multiply-accumulate: one half-width multiplier, four partial
// products per multiply, wide accumulator. Depends on mic_pkg.
module mic_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mic_pkg::t_mac_cmd                i_cmd,
    input  logic signed [mic_pkg::SUB_W-1:0] i_a,
    input  logic signed [mic_pkg::SUB_W-1:0] i_b,
    output mic_pkg::t_mac_st                 o_st,
    output logic [mic_pkg::ACC_W-1:0]        o_acc
);
    import mic_pkg::*;

    logic                  r_busy;
    logic [2:0]            r_cnt;
    logic [SUB_W-1:0]      r_ma;
    logic [SUB_W-1:0]      r_mb;
    logic                  r_sub;
    logic [2*HALF_W-1:0]   r_pp;
    logic [1:0]            r_sh;
    logic [ACC_W-1:0]      r_acc;

    logic [HALF_W-1:0]     ha;
    logic [HALF_W-1:0]     hb;
    logic [2*HALF_W-1:0]   n_pp;
    logic [ACC_W-1:0]      addend;
    logic [SUB_W-1:0]      mag_a;
    logic [SUB_W-1:0]      mag_b;

    assign mag_a = i_a[SUB_W-1] ? SUB_W'(-i_a) : SUB_W'(i_a);
    assign mag_b = i_b[SUB_W-1] ? SUB_W'(-i_b) : SUB_W'(i_b);

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                ha = r_ma[HALF_W-1:0];
                hb = r_mb[HALF_W-1:0];
            end
            2'd1: begin
                ha = r_ma[HALF_W-1:0];
                hb = HALF_W'(r_mb >> HALF_W);
            end
            2'd2: begin
                ha = HALF_W'(r_ma >> HALF_W);
                hb = r_mb[HALF_W-1:0];
            end
            default: begin
                ha = HALF_W'(r_ma >> HALF_W);
                hb = HALF_W'(r_mb >> HALF_W);
            end
        endcase
    end

    assign n_pp = ha * hb;

    always_comb begin
        case (r_sh)
            2'd0:    addend = ACC_W'(r_pp);
            2'd3:    addend = ACC_W'(r_pp) << (2 * HALF_W);
            default: addend = ACC_W'(r_pp) << HALF_W;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_ma   <= mag_a;
            r_mb   <= mag_b;
            r_sub  <= i_a[SUB_W-1] ^ i_b[SUB_W-1] ^ i_cmd.neg;
            if (i_cmd.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_cnt != MAC_LAST) begin
                r_pp <= n_pp;
                r_sh <= r_cnt[1:0];
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_sub ? r_acc - addend : r_acc + addend;
            end
            if (r_cnt == MAC_LAST) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 3'd1;
        end
    end

    assign o_st.busy = r_busy;
    assign o_acc     = r_acc;
endmodule

>>> rtl/mic_div.sv
// Restoring divider, one quotient bit per cycle, QUO_W bits of quotient.
// Depends on mic_pkg.
module mic_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mic_pkg::NUM_W-1:0] i_num,
    input  logic [mic_pkg::DEN_W-1:0] i_den,
    output mic_pkg::t_div_st          o_st
);
    import mic_pkg::*;

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic              ge;

    assign ge = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= DIV_W'(i_num);
            r_dsh  <= DIV_W'(i_den) << (QUO_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            if (r_cnt == DCNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + DCNT_W'(1);
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.quo  = r_quo;
endmodule

>>> rtl/matrix4_inverse_cofactor_unit.sv
// 4x4 matrix inverse, signed Q16.16. Elements are written one beat each, by
// row-major index, in any order but with index 15 last: the beat with index
// 15 starts an inversion and the input stays not ready until all 16 result
// beats have left. The inversion runs on one shared multiply-accumulate unit
// (four 24x24-bit partial products per multiply) for 12 sub-determinants,
// the determinant and 48 adjugate terms, and on a restoring divider per
// result. A singular matrix (|det| at or below det_threshold) skips the
// adjugate and yields 16 zero beats with singular set. det_threshold is
// register 0 at APB address 0.
// Depends on mic_pkg, mic_in_if, mic_out_if, mic_mac, mic_div.
`include "matrix4_inverse_cofactor_unit_defines.svh"
module matrix4_inverse_cofactor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mic_in_if.sink                         i_elem,
    mic_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mic_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mic_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mic_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mic_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FA, S_FB, S_MS, S_MW, S_NX, S_DW, S_OT
    } t_state;

    t_state                   r_state;
    t_phase                   r_phase;
    logic [IDX_W-1:0]         r_k;
    logic [2:0]               r_t;
    logic [THR_W-1:0]         r_thr;
    logic                     r_sing;
    logic                     r_det_neg;
    logic                     r_adj_neg;
    logic [ACC_W-1:0]         r_adet;
    logic [ELEM_W-1:0]        r_out_val;
    logic signed [SUB_W-1:0]  r_rd;
    logic signed [SUB_W-1:0]  r_opa;
    logic [ELEM_W-1:0]        mat_mem [ELEM_N];
    logic [SUB_W-1:0]         sub_mem [SUB_N];

    t_op                      op;
    logic [2:0]               t_last;
    logic                     rd_sub;
    logic [IDX_W-1:0]         rd_addr;
    logic [ACC_W-1:0]         acc;
    logic                     acc_neg;
    logic [ACC_W-1:0]         acc_mag;
    logic signed [ACC_W-1:0]  acc_shr;
    logic [ACC_W-1:0]         lim;
    logic                     sing_now;
    logic [NUM_W-1:0]         num;
    logic [DEN_W-1:0]         den;
    logic [ELEM_W-1:0]        val_pos;
    logic [ELEM_W-1:0]        val_neg;
    logic                     cfg_wr;
    logic                     in_acc;
    logic                     out_acc;
    logic                     div_start;
    t_mac_cmd                 mac_cmd;
    t_mac_st                  mac_st;
    t_div_st                  div_st;

    assign op      = op_decode(r_phase, r_k, r_t);
    assign rd_sub  = (r_state == S_FA) ? op.a_sub : op.b_sub;
    assign rd_addr = (r_state == S_FA) ? op.a_idx : op.b_idx;

    always_comb begin
        case (r_phase)
            PH_SUB:  t_last = T_LAST_SUB;
            PH_DET:  t_last = T_LAST_DET;
            default: t_last = T_LAST_ADJ;
        endcase
    end

    assign acc_neg  = acc[ACC_W-1];
    assign acc_mag  = acc_neg ? ACC_W'(-acc) : acc;
    assign acc_shr  = $signed(acc) >>> FRAC_BITS;
    assign lim      = ACC_W'(r_thr) << FRAC_BITS;
    assign sing_now = acc_mag <= lim;
    assign num      = (NUM_W'(acc_mag) << (FRAC_BITS + 1)) + NUM_W'(r_adet);
    assign den      = DEN_W'(r_adet) << 1;

    assign val_pos = (div_st.quo > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                           : div_st.quo[ELEM_W-1:0];
    assign val_neg = (div_st.quo > QUO_W'(32'h8000_0000)) ? 32'h8000_0000
                                                           : 32'd0 - div_st.quo[ELEM_W-1:0];

    assign cfg_wr  = psel && penable && pwrite;
    assign in_acc  = i_elem.valid && i_elem.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_THR) ? APB_DATA_W'(r_thr) : '0;

    assign div_start = (r_state == S_NX) && (r_phase == PH_ADJ) && (r_t == t_last);

    assign mac_cmd.start = (r_state == S_MS);
    assign mac_cmd.clr   = (r_t == 3'd0);
    assign mac_cmd.neg   = op.neg;

    mic_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_a     (r_opa),
        .i_b     (r_rd),
        .o_st    (mac_st),
        .o_acc   (acc)
    );

    mic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_st    (div_st)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mat_mem[i_elem.elem_index] <= i_elem.elem_value;
        end
        if (div_start == 1'b0 && r_state == S_NX && r_phase == PH_SUB && r_t == t_last) begin
            sub_mem[r_k] <= acc_shr[SUB_W-1:0];
        end
        if (r_state == S_FA || r_state == S_FB) begin
            r_rd <= rd_sub ? sub_mem[rd_addr]
                           : {{(SUB_W - ELEM_W){mat_mem[rd_addr][ELEM_W-1]}},
                              mat_mem[rd_addr]};
        end
        if (r_state == S_FB) begin
            r_opa <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_SUB;
            r_k       <= '0;
            r_t       <= '0;
            r_thr     <= THR_RESET;
            r_sing    <= 1'b0;
            r_det_neg <= 1'b0;
            r_adj_neg <= 1'b0;
            r_adet    <= '0;
            r_out_val <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_THR) begin
                r_thr <= pwdata[THR_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_elem.elem_index == IDX_LAST) begin
                        r_phase <= PH_SUB;
                        r_k     <= '0;
                        r_t     <= '0;
                        r_state <= S_FA;
                    end
                end
                S_FA: r_state <= S_FB;
                S_FB: r_state <= S_MS;
                S_MS: r_state <= S_MW;
                S_MW: begin
                    if (!mac_st.busy) begin
                        r_state <= S_NX;
                    end
                end
                S_NX: begin
                    if (r_t != t_last) begin
                        r_t     <= r_t + 3'd1;
                        r_state <= S_FA;
                    end else begin
                        r_t <= '0;
                        case (r_phase)
                            PH_SUB: begin
                                if (r_k == K_LAST_SUB) begin
                                    r_phase <= PH_DET;
                                    r_k     <= '0;
                                end else begin
                                    r_k <= r_k + 4'd1;
                                end
                                r_state <= S_FA;
                            end
                            PH_DET: begin
                                r_adet    <= acc_mag;
                                r_det_neg <= acc_neg;
                                r_sing    <= sing_now;
                                r_phase   <= PH_ADJ;
                                r_k       <= '0;
                                if (sing_now) begin
                                    r_out_val <= '0;
                                    r_state   <= S_OT;
                                end else begin
                                    r_state <= S_FA;
                                end
                            end
                            PH_ADJ: begin
                                r_adj_neg <= acc_neg ^ r_det_neg;
                                r_state   <= S_DW;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DW: begin
                    if (!div_st.busy) begin
                        r_out_val <= r_adj_neg ? val_neg : val_pos;
                        r_state   <= S_OT;
                    end
                end
                S_OT: begin
                    if (o_res.ready) begin
                        if (r_k == IDX_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 4'd1;
                            if (!r_sing) begin
                                r_state <= S_FA;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_elem.ready   = (r_state == S_IDLE);
    assign o_res.valid    = (r_state == S_OT);
    assign o_res.out_index = r_k;
    assign o_res.out_value = r_out_val;
    assign o_res.singular = r_sing;
    assign o_res.last     = (r_k == IDX_LAST);

    `MIC_ASSERT_IMPL(a_idle_units_quiet, i_clk, i_rst_n, r_state == S_IDLE, !mac_st.busy && !div_st.busy, "shared unit busy while idle")
    `MIC_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, out_acc && o_res.last, r_state == S_IDLE, "not idle after last beat")
    `MIC_ASSERT_IMPL(a_singular_zero, i_clk, i_rst_n, o_res.valid && o_res.singular, o_res.out_value == '0, "singular beat carries nonzero value")
    `MIC_ASSERT_NEXT(a_div_started, i_clk, i_rst_n, div_start, div_st.busy, "divider did not start")
endmodule
